// ===== hw/rtl/lca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_pkg
// Shared widths, codes and controller/datapath interface types for the
// binary-lifting lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
package lca_pkg;

	localparam int ID_BITS    = 12;
	localparam int LEVELS     = 12;
	localparam int LVL_BITS   = $clog2(LEVELS);
	localparam int NODE_COUNT = 1 << ID_BITS;
	localparam int ANC_AW     = ID_BITS + LVL_BITS;
	localparam int ANC_DEPTH  = 1 << ANC_AW;
	// wide enough for depth + 2^level without overflow
	localparam int DSUM_W     = ((ID_BITS > LEVELS) ? ID_BITS : LEVELS) + 1;
	localparam int S_DATA_W   = ((2 * ID_BITS + 7) / 8) * 8;
	localparam int M_DATA_W   = ((ID_BITS + 7) / 8) * 8;

	typedef logic [ID_BITS-1:0]  node_t;
	typedef logic [LVL_BITS-1:0] lvl_t;

	localparam node_t DEPTH_MAX = '1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		DEP_IN_A  = 2'd0,
		DEP_IN_B  = 2'd1,
		DEP_REG_B = 2'd2,
		DEP_ANC   = 2'd3
	} dep_src_t;

	typedef enum logic [1:0] {
		ANC_A      = 2'd0,
		ANC_B      = 2'd1,
		ANC_B_PREV = 2'd2
	} anc_src_t;

	typedef struct packed {
		logic     load;
		logic     dep_rd;
		dep_src_t dep_src;
		logic     anc_rd;
		anc_src_t anc_src;
		logic     add_first;
		logic     add_level;
		logic     cap_da;
		logic     cap_db;
		logic     lvl_top;
		logic     lvl_dec;
		logic     lift_a;
		logic     cap_pa;
		logic     cmp_step;
		logic     out_load;
		logic     out_sel_b;
	} dp_cmd_t;

	typedef struct packed {
		logic in_query;
		logic in_node_zero;
		logic lift_ok;
		logic lvl_zero;
		logic lvl_last;
		logic a_eq_b;
	} dp_status_t;

endpackage

// ===== hw/rtl/lca_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/lca_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_datapath
// Depth and ancestor memories, node/depth/level registers, lift compare and
// result register.
// ----------------------------------------------------------------------------
module lca_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lca_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                         s_tuser,
	input  lca_pkg::dp_cmd_t             cmd,
	output lca_pkg::dp_status_t          st,
	output logic [lca_pkg::M_DATA_W-1:0] m_tdata
);

	lca_pkg::node_t in_a, in_b;
	lca_pkg::node_t a_q, b_q, da_q, db_q, pa_q, out_q;
	lca_pkg::lvl_t  lvl_q;

	lca_pkg::node_t dep_raddr, dep_rdata, dep_data, d_next;
	logic           dep_zero_q;

	lca_pkg::node_t                 anc_node, anc_rdata, anc_data, lvl_val;
	lca_pkg::lvl_t                  anc_lvl;
	logic [lca_pkg::ANC_AW-1:0]     anc_raddr, anc_waddr;
	lca_pkg::node_t                 anc_wdata;
	logic                           anc_we;
	logic                           anc_zero_q;
	logic [lca_pkg::DSUM_W-1:0]     pow;

	assign in_a = s_tdata[lca_pkg::ID_BITS-1:0];
	assign in_b = s_tdata[2*lca_pkg::ID_BITS-1:lca_pkg::ID_BITS];

	// depth memory read select
	always_comb begin
		case (cmd.dep_src)
			lca_pkg::DEP_IN_A:  dep_raddr = in_a;
			lca_pkg::DEP_IN_B:  dep_raddr = in_b;
			lca_pkg::DEP_REG_B: dep_raddr = b_q;
			lca_pkg::DEP_ANC:   dep_raddr = anc_data;
			default:            dep_raddr = b_q;
		endcase
	end

	// ancestor memory read select; add walks use the previous level
	always_comb begin
		case (cmd.anc_src)
			lca_pkg::ANC_A: begin
				anc_node = a_q;
				anc_lvl  = lvl_q;
			end
			lca_pkg::ANC_B: begin
				anc_node = b_q;
				anc_lvl  = lvl_q;
			end
			lca_pkg::ANC_B_PREV: begin
				anc_node = b_q;
				anc_lvl  = lvl_q - lca_pkg::LVL_BITS'(1);
			end
			default: begin
				anc_node = b_q;
				anc_lvl  = lvl_q;
			end
		endcase
	end

	assign anc_raddr = {anc_node, anc_lvl};

	// node zero is never written and always reads as zero
	assign dep_data = dep_zero_q ? '0 : dep_rdata;
	assign anc_data = anc_zero_q ? '0 : anc_rdata;

	assign d_next  = (dep_data == lca_pkg::DEPTH_MAX) ? lca_pkg::DEPTH_MAX
	                                                  : dep_data + lca_pkg::node_t'(1);
	assign pow     = lca_pkg::DSUM_W'(1) << lvl_q;
	assign lvl_val = (pow <= lca_pkg::DSUM_W'(da_q)) ? anc_data : '0;

	assign anc_we    = cmd.add_first | cmd.add_level;
	assign anc_waddr = {a_q, cmd.add_first ? lca_pkg::lvl_t'(0) : lvl_q};
	assign anc_wdata = cmd.add_first ? b_q : lvl_val;

	lca_ram #(
		.WIDTH(lca_pkg::ID_BITS),
		.DEPTH(lca_pkg::NODE_COUNT)
	) u_dep_ram (
		.clk  (clk),
		.we   (cmd.add_first),
		.waddr(a_q),
		.wdata(d_next),
		.re   (cmd.dep_rd),
		.raddr(dep_raddr),
		.rdata(dep_rdata)
	);

	lca_ram #(
		.WIDTH(lca_pkg::ID_BITS),
		.DEPTH(lca_pkg::ANC_DEPTH)
	) u_anc_ram (
		.clk  (clk),
		.we   (anc_we),
		.waddr(anc_waddr),
		.wdata(anc_wdata),
		.re   (cmd.anc_rd),
		.raddr(anc_raddr),
		.rdata(anc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.add_first) begin
			lvl_q <= lca_pkg::LVL_BITS'(1);
		end else if (cmd.add_level) begin
			lvl_q <= lvl_q + lca_pkg::LVL_BITS'(1);
		end else if (cmd.lvl_top) begin
			lvl_q <= lca_pkg::LVL_BITS'(lca_pkg::LEVELS - 1);
		end else if (cmd.lvl_dec) begin
			lvl_q <= lvl_q - lca_pkg::LVL_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dep_rd) begin
			dep_zero_q <= (dep_raddr == '0);
		end
		if (cmd.anc_rd) begin
			anc_zero_q <= (anc_node == '0);
		end

		if (cmd.load) begin
			a_q <= in_a;
			b_q <= in_b;
		end else if (cmd.cap_db) begin
			if (da_q < dep_data) begin
				a_q  <= b_q;
				b_q  <= a_q;
				da_q <= dep_data;
				db_q <= da_q;
			end else begin
				db_q <= dep_data;
			end
		end else if (cmd.add_level) begin
			b_q <= lvl_val;
		end else if (cmd.lift_a) begin
			a_q <= anc_data;
		end else if (cmd.cmp_step) begin
			if (pa_q != anc_data) begin
				a_q <= pa_q;
				b_q <= anc_data;
			end
		end

		if (cmd.add_first) begin
			da_q <= d_next;
		end else if (cmd.cap_da) begin
			da_q <= dep_data;
		end

		if (cmd.cap_pa) begin
			pa_q <= anc_data;
		end

		if (cmd.out_load) begin
			out_q <= cmd.out_sel_b ? b_q : anc_data;
		end
	end

	assign st.in_query     = (s_tuser == lca_pkg::CMD_QUERY);
	assign st.in_node_zero = (in_a == '0);
	assign st.lift_ok      = lca_pkg::DSUM_W'(da_q) >= (lca_pkg::DSUM_W'(db_q) + pow);
	assign st.lvl_zero     = (lvl_q == '0);
	assign st.lvl_last     = (lvl_q == lca_pkg::LVL_BITS'(lca_pkg::LEVELS - 1));
	assign st.a_eq_b       = (a_q == b_q);

	assign m_tdata = lca_pkg::M_DATA_W'(out_q);

`ifndef NO_ASSERTIONS
	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_level |-> lvl_q != '0)
		else $error("ancestor level write at level zero");

	a_first_sets_level: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_first |=> lvl_q == lca_pkg::LVL_BITS'(1))
		else $error("add walk did not start at level one");
`endif

endmodule

// ===== hw/rtl/lca_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lca_ctrl
// Sequencer for add and query transactions; owns input ready and result valid.
// ----------------------------------------------------------------------------
module lca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  lca_pkg::dp_status_t st,
	output lca_pkg::dp_cmd_t    cmd
);

	typedef enum logic [15:0] {
		ST_IDLE    = 16'h0001,
		ST_ADD_DEP = 16'h0002,
		ST_ADD_RD  = 16'h0004,
		ST_ADD_WR  = 16'h0008,
		ST_Q_DA    = 16'h0010,
		ST_Q_DB    = 16'h0020,
		ST_Q_LIFT  = 16'h0040,
		ST_Q_LA    = 16'h0080,
		ST_Q_LD    = 16'h0100,
		ST_Q_EQ    = 16'h0200,
		ST_Q_PA    = 16'h0400,
		ST_Q_PB    = 16'h0800,
		ST_Q_CMP   = 16'h1000,
		ST_Q_FIN   = 16'h2000,
		ST_Q_RES   = 16'h4000,
		ST_Q_BRES  = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (st.in_query) begin
						cmd.dep_rd  = 1'b1;
						cmd.dep_src = lca_pkg::DEP_IN_A;
						state_d     = ST_Q_DA;
					end else if (!st.in_node_zero) begin
						cmd.dep_rd  = 1'b1;
						cmd.dep_src = lca_pkg::DEP_IN_B;
						state_d     = ST_ADD_DEP;
					end
				end
			end
			ST_ADD_DEP: begin
				cmd.add_first = 1'b1;
				state_d       = ST_ADD_RD;
			end
			ST_ADD_RD: begin
				cmd.anc_rd  = 1'b1;
				cmd.anc_src = lca_pkg::ANC_B_PREV;
				state_d     = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				cmd.add_level = 1'b1;
				state_d       = st.lvl_last ? ST_IDLE : ST_ADD_RD;
			end
			ST_Q_DA: begin
				cmd.cap_da  = 1'b1;
				cmd.dep_rd  = 1'b1;
				cmd.dep_src = lca_pkg::DEP_REG_B;
				state_d     = ST_Q_DB;
			end
			ST_Q_DB: begin
				cmd.cap_db  = 1'b1;
				cmd.lvl_top = 1'b1;
				state_d     = ST_Q_LIFT;
			end
			ST_Q_LIFT: begin
				if (st.lift_ok) begin
					cmd.anc_rd  = 1'b1;
					cmd.anc_src = lca_pkg::ANC_A;
					state_d     = ST_Q_LA;
				end else if (st.lvl_zero) begin
					state_d = ST_Q_EQ;
				end else begin
					cmd.lvl_dec = 1'b1;
				end
			end
			ST_Q_LA: begin
				// lifted node addresses its own depth straight from the read data
				cmd.lift_a  = 1'b1;
				cmd.dep_rd  = 1'b1;
				cmd.dep_src = lca_pkg::DEP_ANC;
				state_d     = ST_Q_LD;
			end
			ST_Q_LD: begin
				cmd.cap_da = 1'b1;
				if (st.lvl_zero) begin
					state_d = ST_Q_EQ;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_d     = ST_Q_LIFT;
				end
			end
			ST_Q_EQ: begin
				if (st.a_eq_b) begin
					state_d = ST_Q_BRES;
				end else begin
					cmd.lvl_top = 1'b1;
					state_d     = ST_Q_PA;
				end
			end
			ST_Q_PA: begin
				cmd.anc_rd  = 1'b1;
				cmd.anc_src = lca_pkg::ANC_A;
				state_d     = ST_Q_PB;
			end
			ST_Q_PB: begin
				cmd.cap_pa  = 1'b1;
				cmd.anc_rd  = 1'b1;
				cmd.anc_src = lca_pkg::ANC_B;
				state_d     = ST_Q_CMP;
			end
			ST_Q_CMP: begin
				cmd.cmp_step = 1'b1;
				if (st.lvl_zero) begin
					state_d = ST_Q_FIN;
				end else begin
					cmd.lvl_dec = 1'b1;
					state_d     = ST_Q_PA;
				end
			end
			ST_Q_FIN: begin
				// level is zero here: fetch the parent of b
				cmd.anc_rd  = 1'b1;
				cmd.anc_src = lca_pkg::ANC_B;
				state_d     = ST_Q_RES;
			end
			ST_Q_RES: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_Q_BRES: begin
				if (out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_sel_b = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_zero_add_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !st.in_query && st.in_node_zero |=> state_q == ST_IDLE)
		else $error("add of node zero was not dropped");

	a_valid_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_Q_RES || $past(state_q) == ST_Q_BRES))
		else $error("result raised outside a result state");

	a_no_dec_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lvl_dec |-> !st.lvl_zero)
		else $error("level counter underflow");
`endif

endmodule

// ===== hw/rtl/lowest_common_ancestor_engine_top.sv =====
`timescale 1ns / 1ps
// Add transaction: one ancestor-table read and write per level above zero,
//   on its single read port; level zero is written with the parent directly.
// Query transaction: an early match of the equalized nodes ends sooner.
// One transaction in flight; a result waits in the output register.
// Reset clears the sequencer and output valid; table contents are not cleared.
// ----------------------------------------------------------------------------
// lowest_common_ancestor_engine_top
// Binary-lifting lowest-common-ancestor engine: loads nodes with their parents
// and answers common-ancestor queries.
// ----------------------------------------------------------------------------
module lowest_common_ancestor_engine_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lca_pkg::S_DATA_W-1:0] s_tdata,  // node_a, node_b
	input  logic                         s_tuser,  // cmd
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lca_pkg::M_DATA_W-1:0] m_tdata   // common_ancestor
);

	lca_pkg::dp_cmd_t    cmd;
	lca_pkg::dp_status_t st;

	lca_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.st      (st),
		.cmd     (cmd)
	);

	lca_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cmd    (cmd),
		.st     (st),
		.m_tdata(m_tdata)
	);

endmodule
